// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PBP_ASSERT(lbl, clk, rst_n, prop)
`define PBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pbp_pkg.sv =====
// ---------------------------------------------------------------------------
// perceptron branch predictor package
// field widths, register indexes, defaults and shared types
// ---------------------------------------------------------------------------
package pbp_pkg;

    localparam int PC_W       = 32;
    localparam int LR_W       = 5;
    localparam int THR_W      = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam int DEF_HISTORY_LENGTH = 16;
    localparam int DEF_TABLE_ENTRIES  = 256;
    localparam int DEF_WEIGHT_BITS    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRAINING_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [LR_W-1:0]  LR_RESET  = LR_W'(1);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(30);

    typedef struct packed {
        logic [LR_W-1:0]  learning_rate;
        logic [THR_W-1:0] training_threshold;
    } t_cfg;

    typedef struct packed {
        logic pred;
        logic train;
    } t_train_res;

endpackage

// ===== rtl/core/pbp_weight_ram.sv =====
// ---------------------------------------------------------------------------
// weight row memory
// one write port, one registered read port, write data bypassed to a
// read of the same row in the same cycle
// ---------------------------------------------------------------------------
module pbp_weight_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 136
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pbp_train.sv =====
// ---------------------------------------------------------------------------
// perceptron evaluate and train
// sums the selected weights of one row, makes the prediction and builds
// the trained row
// ---------------------------------------------------------------------------
module pbp_train
    import pbp_pkg::*;
#(
    parameter int HISTORY_LENGTH = DEF_HISTORY_LENGTH,
    parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS
) (
    input  logic [(HISTORY_LENGTH+1)*WEIGHT_BITS-1:0] i_row,
    input  logic [HISTORY_LENGTH-1:0]                 i_hist,
    input  logic                                      i_taken,
    input  t_cfg                                      i_cfg,
    output logic [(HISTORY_LENGTH+1)*WEIGHT_BITS-1:0] o_row,
    output t_train_res                                o_res
);

    localparam int PAIRS = HISTORY_LENGTH / 2;
    localparam int SUM_W = WEIGHT_BITS + $clog2(PAIRS + 1) + 1;
    localparam int CMP_W = ((SUM_W > THR_W + 1) ? SUM_W : THR_W + 1) + 1;
    localparam int G_W   = ((WEIGHT_BITS > LR_W + 2) ? WEIGHT_BITS : LR_W + 2) + 2;
    localparam logic signed [G_W-1:0] WMAX_G = G_W'((1 << (WEIGHT_BITS - 1)) - 1);
    localparam logic signed [G_W-1:0] WMIN_G = G_W'(-(1 << (WEIGHT_BITS - 1)));
    localparam logic signed [G_W-1:0] ONE_G  = G_W'(1);

    logic signed [WEIGHT_BITS-1:0] w    [HISTORY_LENGTH+1];
    logic signed [WEIGHT_BITS-1:0] pick [PAIRS];
    logic [PAIRS-1:0]              sel_odd;
    logic [PAIRS-1:0]              even_bit;
    logic signed [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]              mag;
    logic                          pred;
    logic                          train;
    logic signed [G_W-1:0]         d;
    logic signed [G_W-1:0]         inc_lim;
    logic signed [G_W-1:0]         dec_lim;
    logic signed [G_W-1:0]         bias_g;
    logic signed [G_W-1:0]         bias_n;
    logic signed [G_W-1:0]         wg;
    logic signed [G_W-1:0]         wn;

    always_comb begin
        for (int k = 0; k <= HISTORY_LENGTH; k++) begin
            w[k] = i_row[k*WEIGHT_BITS +: WEIGHT_BITS];
        end
        for (int p = 0; p < PAIRS; p++) begin
            even_bit[p] = i_hist[2*p];
            sel_odd[p]  = (i_hist[2*p] == i_hist[2*p+1]);
            pick[p]     = sel_odd[p] ? w[2*p+1] : w[2*p];
        end
    end

    // bias plus each selected weight, negated where the even bit is set
    always_comb begin
        sum = SUM_W'(w[HISTORY_LENGTH]);
        for (int p = 0; p < PAIRS; p++) begin
            if (even_bit[p]) begin
                sum = sum - SUM_W'(pick[p]);
            end else begin
                sum = sum + SUM_W'(pick[p]);
            end
        end
        pred  = !sum[SUM_W-1];
        mag   = pred ? unsigned'(sum) : unsigned'(-sum);
        train = (pred != i_taken) ||
                (CMP_W'(mag) <= CMP_W'(i_cfg.training_threshold));
    end

    // guards worked out wide enough that no limit wraps
    always_comb begin
        d       = G_W'({i_cfg.learning_rate, 1'b0});
        inc_lim = G_W'(WMAX_G - d + ONE_G);
        dec_lim = G_W'(WMIN_G + d - ONE_G);
        bias_g  = G_W'(w[HISTORY_LENGTH]);
        bias_n  = bias_g;
        wg      = '0;
        wn      = '0;
        o_row   = i_row;
        if (train) begin
            if (i_taken) begin
                if ((bias_g < inc_lim) && (bias_g < WMAX_G)) begin
                    bias_n = bias_g + ONE_G;
                end
            end else begin
                if ((bias_g > dec_lim) && (bias_g > WMIN_G)) begin
                    bias_n = bias_g - ONE_G;
                end
            end
            o_row[HISTORY_LENGTH*WEIGHT_BITS +: WEIGHT_BITS] = bias_n[WEIGHT_BITS-1:0];
            for (int p = 0; p < PAIRS; p++) begin
                wg = G_W'(pick[p]);
                wn = wg;
                if (even_bit[p] == i_taken) begin
                    if (wg > dec_lim) begin
                        wn = wg - d;
                    end
                end else begin
                    if (wg < inc_lim) begin
                        wn = wg + d;
                    end
                end
                o_row[(2*p + (sel_odd[p] ? 1 : 0))*WEIGHT_BITS +: WEIGHT_BITS] =
                    wn[WEIGHT_BITS-1:0];
            end
        end
    end

    assign o_res.pred  = pred;
    assign o_res.train = train;

endmodule

// ===== rtl/core/perceptron_branch_predictor_unit.sv =====
// ---------------------------------------------------------------------------
// perceptron branch predictor unit
// predicts one branch per transaction from a pc-indexed weight row and the
// global history, then trains the row and shifts the outcome into history
//
//  channel  dir  signals                                   carries
//  s        in   i_s_tvalid o_s_tready i_s_tdata[39:0]     pc, actual_taken
//  m        out  o_m_tvalid i_m_tready o_m_tdata[7:0]      predicted_taken
//  cfg      in   i_cfg_valid o_cfg_ready i_cfg_index/data  register writes
//
// one branch accepted per cycle sustained while the m side takes results; each
// branch passes the input register, the row read and the result register
// the weight memory has one read and one write port; a row trained in one
// cycle is bypassed to a read of the same row in that cycle
// after reset a clearing pass writes zero to every row with o_s_tready low;
// o_cfg_ready is always high
// a stalled m side holds the result register, then stage one, then the input
// register, before o_s_tready drops
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module perceptron_branch_predictor_unit
    import pbp_pkg::*;
#(
    parameter int HISTORY_LENGTH = DEF_HISTORY_LENGTH,
    parameter int TABLE_ENTRIES  = DEF_TABLE_ENTRIES,
    parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // pc [31:0], actual_taken [32], zero
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // predicted_taken [0], zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int  IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int  ROW_W    = (HISTORY_LENGTH + 1) * WEIGHT_BITS;
    localparam int  FOLD_W   = IDX_W + 5;
    localparam bit  ROW_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

    // 2^k mod TABLE_ENTRIES by repeated doubling
    function automatic int pow_mod(input int k);
        int m;
        m = 1;
        for (int j = 0; j < k; j++) begin
            m = m * 2;
            if (m >= TABLE_ENTRIES) begin
                m = m - TABLE_ENTRIES;
            end
        end
        return m;
    endfunction

    t_cfg                      r_cfg;
    logic                      r_clr_busy;
    logic [IDX_W-1:0]          r_clr_addr;
    logic                      r_s0_valid;
    logic [PC_W-1:0]           r_s0_pc;
    logic                      r_s0_taken;
    logic                      r_s1_valid;
    logic [IDX_W-1:0]          r_s1_row;
    logic                      r_s1_taken;
    logic [HISTORY_LENGTH-1:0] r_hist;
    logic [HISTORY_LENGTH-1:0] n_hist;
    logic                      r_out_valid;
    logic                      r_out_pred;

    logic                      out_free;
    logic                      s1_fire;
    logic                      s1_free;
    logic                      s0_xfer;
    logic                      in_acc;
    logic [IDX_W-1:0]          rd_addr;
    logic [ROW_W-1:0]          rd_data;
    logic [ROW_W-1:0]          new_row;
    t_train_res                res;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [ROW_W-1:0]          mem_wdata;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && out_free;
    assign s1_free    = !r_s1_valid || s1_fire;
    assign s0_xfer    = r_s0_valid && s1_free;
    assign o_s_tready = (!r_s0_valid || s0_xfer) && !r_clr_busy;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate      <= LR_RESET;
            r_cfg.training_threshold <= THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEARNING_RATE: begin
                    r_cfg.learning_rate <= i_cfg_data[LR_W-1:0];
                end
                REG_TRAINING_THRESHOLD: begin
                    r_cfg.training_threshold <= i_cfg_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clearing pass over the weight memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (in_acc) begin
            r_s0_valid <= 1'b1;
        end else if (s0_xfer) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_pc    <= i_s_tdata[PC_W-1:0];
            r_s0_taken <= i_s_tdata[PC_W];
        end
    end

    // row index: pc modulo the table size
    if (ROW_POW2) begin : g_row_mask
        assign rd_addr = r_s0_pc[IDX_W-1:0];
    end else begin : g_row_fold
        logic [FOLD_W-1:0] fold;
        always_comb begin
            fold = '0;
            for (int k = 0; k < PC_W; k++) begin
                if (r_s0_pc[k]) begin
                    fold = fold + FOLD_W'(pow_mod(k));
                end
            end
            for (int s = 4; s >= 0; s--) begin
                if (fold >= (FOLD_W'(TABLE_ENTRIES) << s)) begin
                    fold = fold - (FOLD_W'(TABLE_ENTRIES) << s);
                end
            end
        end
        assign rd_addr = fold[IDX_W-1:0];
    end

    // stage one: row data arrives from the memory read register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_xfer) begin
            r_s1_row   <= rd_addr;
            r_s1_taken <= r_s0_taken;
        end
    end

    assign mem_we    = r_clr_busy || (s1_fire && res.train);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s1_row;
    assign mem_wdata = r_clr_busy ? '0 : new_row;

    pbp_weight_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .DATA_W (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (s0_xfer),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    pbp_train #(
        .HISTORY_LENGTH (HISTORY_LENGTH),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_train (
        .i_row   (rd_data),
        .i_hist  (r_hist),
        .i_taken (r_s1_taken),
        .i_cfg   (r_cfg),
        .o_row   (new_row),
        .o_res   (res)
    );

    // newest outcome enters at the top bit
    assign n_hist = {r_s1_taken, r_hist[HISTORY_LENGTH-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (s1_fire) begin
            r_hist <= n_hist;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pred <= res.pred;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - 1)'(0), r_out_pred};

    `PBP_ASSERT(a_clear_idle, i_clk, i_rst_n, r_clr_busy |-> (!r_s0_valid && !r_s1_valid && !r_out_valid))
    `PBP_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_fire, r_s1_valid && $stable(r_s1_row) && $stable(rd_data))
    `PBP_ASSERT_NEXT(a_row_bypass, i_clk, i_rst_n, s0_xfer && s1_fire && res.train && (rd_addr == r_s1_row), rd_data == $past(new_row))
    `PBP_ASSERT_NEXT(a_hist_shift, i_clk, i_rst_n, s1_fire, r_hist[HISTORY_LENGTH-1] == $past(r_s1_taken))
    `PBP_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, s1_fire, r_out_valid && (r_out_pred == $past(res.pred)))

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// perceptron branch predictor unit testbench
// drives branches into the slave stream, predicts every prediction in a
// local model of the weight table and global history, and compares each
// result on the master stream in order; configuration is changed between
// phases once the unit has drained, under bursty input and a stalling sink
// ---------------------------------------------------------------------------
module testbench
    import pbp_pkg::*;
();

    localparam int HIST        = DEF_HISTORY_LENGTH;
    localparam int ROWS        = DEF_TABLE_ENTRIES;
    localparam int WB          = DEF_WEIGHT_BITS;
    localparam int PAIRS       = HIST / 2;
    localparam int WMAX        = (1 << (WB - 1)) - 1;
    localparam int WMIN        = -(1 << (WB - 1));
    localparam int N_DIRECTED  = 20;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int N_HOT       = 8;
    localparam int DRAIN_WAIT  = 4;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic            taken;
        logic            typed;
        logic            exp_pred;
    } t_branch_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;   // pc [31:0], actual_taken [32], zero
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;   // predicted_taken [0], zero
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // travels alongside tdata so the monitor knows which rows carry a typed answer
    logic                  row_typed;
    logic                  row_exp;

    // local copy of the predictor state
    logic signed [WB-1:0]  weights [ROWS][HIST+1];
    logic [HIST-1:0]       ghist;
    logic [LR_W-1:0]       cur_lr;
    logic [THR_W-1:0]      cur_thr;

    logic                  pred_q [$];
    int                    mismatches = 0;
    int                    branches_in = 0;
    int                    idle_cycles = 0;

    // hot rows first, then repeated training of one row, then mixed rows
    t_branch_row directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
        '{32'h5555_5555, 1'b1, 1'b1, 1'b1},
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1},
        '{32'h0000_0100, 1'b0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0},
        '{32'h0000_0012, 1'b0, 1'b1, 1'b1},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0},
        '{32'hDEAD_BE12, 1'b1, 1'b0, 1'b0},
        '{32'hDEAD_BE12, 1'b1, 1'b0, 1'b0},
        '{32'hDEAD_BE12, 1'b1, 1'b0, 1'b0},
        '{32'hDEAD_BE12, 1'b1, 1'b0, 1'b0},
        '{32'h7FFF_FF00, 1'b1, 1'b0, 1'b0},
        '{32'h0000_00FF, 1'b0, 1'b0, 1'b0},
        '{32'h1234_5601, 1'b1, 1'b1, 1'b1},
        '{32'hFEDC_BA01, 1'b0, 1'b0, 1'b0}
    };

    // rate and threshold zero, largest step both ways, reset values, 3 and 100, random
    logic [LR_W-1:0]  phase_lr  [N_PHASES] = '{5'd0, 5'd31, 5'd31, LR_RESET, 5'd3, 5'd0};
    logic [THR_W-1:0] phase_thr [N_PHASES] = '{11'd0, 11'd2047, 11'd0, THR_RESET, 11'd100,
                                               11'd0};

    perceptron_branch_predictor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic predict_and_train(input logic [PC_W-1:0] pc, input logic taken);
        int   row;
        int   step;
        int   inc_lim;
        int   dec_lim;
        int   total;
        int   mag;
        int   w;
        int   slot;
        logic pred;
        logic e;
        logic o;
        row     = int'(pc % PC_W'(ROWS));
        step    = 2 * int'(cur_lr);
        inc_lim = WMAX - step + 1;
        dec_lim = WMIN + step - 1;
        total   = int'(weights[row][HIST]);
        for (int p = 0; p < PAIRS; p++) begin
            e     = ghist[2*p];
            o     = ghist[2*p+1];
            slot  = (e == o) ? 2*p + 1 : 2*p;
            w     = int'(weights[row][slot]);
            total = e ? total - w : total + w;
        end
        pred = (total >= 0);
        mag  = pred ? total : -total;
        if (pred != taken || mag <= int'(cur_thr)) begin
            w = int'(weights[row][HIST]);
            if (taken) begin
                if (w < inc_lim && w < WMAX) w++;
            end else begin
                if (w > dec_lim && w > WMIN) w--;
            end
            weights[row][HIST] = w[WB-1:0];
            for (int p = 0; p < PAIRS; p++) begin
                e    = ghist[2*p];
                o    = ghist[2*p+1];
                slot = (e == o) ? 2*p + 1 : 2*p;
                w    = int'(weights[row][slot]);
                if (e == taken) begin
                    if (w > dec_lim) w -= step;
                end else begin
                    if (w < inc_lim) w += step;
                end
                weights[row][slot] = w[WB-1:0];
            end
        end
        ghist = {taken, ghist[HIST-1:1]};
        return pred;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // caller must be just after a rising edge; returns once the transaction is taken
    task automatic send_branch(input logic [PC_W-1:0] pc, input logic taken,
                               input logic typed, input logic exp_pred);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-PC_W-1){1'b0}}, taken, pc};
        row_typed  <= typed;
        row_exp    <= exp_pred;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic drain_unit;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pred_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // monitor: sample handshakes at the edge, check results before queueing new branches
    always @(posedge i_clk) begin
        logic exp_pred;
        logic model_pred;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int s = 0; s <= HIST; s++) weights[r][s] = '0;
            end
            ghist   = '0;
            cur_lr  = LR_RESET;
            cur_thr = THR_RESET;
        end else begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pred_q.size() == 0) begin
                    report_mismatch($sformatf("prediction %0b with no branch pending",
                                              o_m_tdata[0]));
                end else begin
                    exp_pred = pred_q.pop_front();
                    if (o_m_tdata[0] !== exp_pred) begin
                        report_mismatch($sformatf("predicted_taken %0b, expected %0b",
                                                  o_m_tdata[0], exp_pred));
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                model_pred = predict_and_train(i_s_tdata[PC_W-1:0], i_s_tdata[PC_W]);
                pred_q.push_back(row_typed ? row_exp : model_pred);
                branches_in++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEARNING_RATE: begin
                        cur_lr = i_cfg_data[LR_W-1:0];
                    end
                    REG_TRAINING_THRESHOLD: begin
                        cur_thr = i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // sink: stretches of random stall density, one long hold-off to back up the pipe
    initial begin : sink
        int mode_left;
        int stall_pct;
        int hold_left;
        bit hold_done;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        hold_done = 1'b0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && branches_in >= 400) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 3))
                        0, 1: stall_pct = 0;
                        2:    stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                mode_left--;
                i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : source
        logic [PC_W-1:0]       hot_pcs  [N_HOT];
        int                    hot_seen [N_HOT];
        logic [PC_W-1:0]       pc;
        logic                  taken;
        logic [CFG_DATA_W-1:0] word;
        int                    burst_left;
        int                    gap;
        int                    k;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        row_typed   = 1'b0;
        row_exp     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset configuration
        for (int n = 0; n < N_DIRECTED; n++) begin
            send_branch(directed_rows[n].pc, directed_rows[n].taken,
                        directed_rows[n].typed, directed_rows[n].exp_pred);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_unit();
            word = CFG_DATA_W'($urandom);
            word[LR_W-1:0] = (ph == N_PHASES - 1) ? LR_W'($urandom) : phase_lr[ph];
            write_reg(REG_LEARNING_RATE, word);
            word = CFG_DATA_W'($urandom);
            word[THR_W-1:0] = (ph == N_PHASES - 1) ? THR_W'($urandom) : phase_thr[ph];
            write_reg(REG_TRAINING_THRESHOLD, word);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);

            for (int h = 0; h < N_HOT; h++) begin
                hot_pcs[h]  = $urandom;
                hot_seen[h] = 0;
            end
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        i_s_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;
                k = $urandom_range(0, N_HOT - 1);
                case ($urandom_range(0, 9))
                    0, 1: begin
                        pc    = $urandom;
                        taken = 1'($urandom_range(0, 1));
                    end
                    2, 3: begin
                        pc    = hot_pcs[k];
                        taken = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        // loop-like outcome per hot branch; last two saturate the bias
                        pc = hot_pcs[k];
                        if (k == N_HOT - 1)      taken = 1'b0;
                        else if (k == N_HOT - 2) taken = 1'b1;
                        else                     taken = (hot_seen[k] % (k + 2)) != 0;
                        hot_seen[k]++;
                    end
                endcase
                send_branch(pc, taken, 1'b0, 1'b0);
            end
        end

        drain_unit();
        if (mismatches == 0 && pred_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pbp_pkg.sv
rtl/core/pbp_weight_ram.sv
rtl/core/pbp_train.sv
rtl/core/perceptron_branch_predictor_unit.sv
sim/testbench.sv
